@@ hdl/rbdd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbdd_pkg
// Shared constants and types of the raw block delta decoder.
// ----------------------------------------------------------------------------
package rbdd_pkg;

    localparam int RES_BITS      = 144;
    localparam int BLK_BITS      = 135;
    localparam int BLOCK_PIXELS  = 16;
    localparam int MAX_ROW_WIDTH = 16384;
    localparam int MAX_HEIGHT    = 16384;

    localparam logic [10:0] PIX_MAX = 11'h7ff;

    localparam logic [2:0] CFG_KNEE_ONE     = 3'd0;
    localparam logic [2:0] CFG_KNEE_TWO     = 3'd1;
    localparam logic [2:0] CFG_KNEE_THREE   = 3'd2;
    localparam logic [2:0] CFG_KNEE_FOUR    = 3'd3;
    localparam logic [2:0] CFG_ROW_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;

    // One complete compressed block with its placement.
    typedef struct packed {
        logic [BLK_BITS-1:0] bits;
        logic [13:0]         col;
        logic [13:0]         row;
        logic                last_img;
    } t_blk;

    // One reconstructed pixel ahead of the tone curve.
    typedef struct packed {
        logic [11:0] j;
        logic [13:0] col;
        logic [13:0] row;
        logic        last_blk;
        logic        last_img;
    } t_pix;

    typedef struct packed {
        logic cur_v;
        logic pend_v;
        logic stage_v;
    } t_stat;

endpackage

@@ hdl/rbdd_unpack.sv @@
// ----------------------------------------------------------------------------
// rbdd_unpack
// Bit reservoir, row bookkeeping and block completion detection.
// ----------------------------------------------------------------------------
module rbdd_unpack
    import rbdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [14:0] i_width,
    input  logic [14:0] i_height,
    output logic        o_blk_v,
    output t_blk        o_blk
);

    logic [RES_BITS-1:0] r_res, n_res;
    logic [7:0]          r_held, n_held;
    logic [14:0]         r_bytes, n_bytes;
    logic [10:0]         r_blocks, n_blocks;
    logic [13:0]         r_row, n_row;

    logic [15:0]         x, x_next;
    logic                fit, done, last_blk;
    logic [RES_BITS-1:0] res_a, sh_res;
    logic [7:0]          held_a, need;
    logic [14:0]         bytes_inc;
    logic [14:0]         row_inc;

    always_comb begin
        x      = {1'b0, r_blocks[10:1], 5'b0} | {15'b0, r_blocks[0]};
        x_next = {1'b0, r_blocks[10:1] + 10'd1 - {9'b0, ~r_blocks[0]}, 5'b0}
                 | {15'b0, ~r_blocks[0]};
        fit    = ({1'b0, x} + 17'd30) < {2'b0, i_width};
        last_blk = ({1'b0, x_next} + 17'd30) >= {2'b0, i_width};
        res_a  = (r_res & ~({{(RES_BITS-8){1'b0}}, 8'hff} << r_held))
                 | ({{(RES_BITS-8){1'b0}}, i_byte} << r_held);
        held_a = r_held + 8'd8;
        // A block whose two indices match carries one more delta.
        need   = (res_a[25:22] == res_a[29:26]) ? 8'd135 : 8'd128;
        // The index fields are only looked at once the header is complete.
        done   = i_accept && fit && (held_a >= 8'd30) && (held_a >= need);
        sh_res = (need == 8'd135) ? (res_a >> 135) : (res_a >> 128);

        o_blk_v        = done;
        o_blk.bits     = res_a[BLK_BITS-1:0];
        o_blk.col      = x[13:0];
        o_blk.row      = r_row;
        o_blk.last_img = last_blk && ({1'b0, r_row} == i_height - 15'd1);

        n_res    = r_res;
        n_held   = r_held;
        n_bytes  = r_bytes;
        n_blocks = r_blocks;
        n_row    = r_row;
        bytes_inc = r_bytes + 15'd1;
        row_inc   = {1'b0, r_row} + 15'd1;
        if (i_accept) begin
            if (fit) begin
                n_res  = res_a;
                n_held = held_a;
            end
            if (done) begin
                n_res    = sh_res;
                n_held   = held_a - need;
                n_blocks = r_blocks + 11'd1;
            end
            n_bytes = bytes_inc;
            if (bytes_inc >= i_width) begin
                n_bytes  = '0;
                n_blocks = '0;
                n_held   = '0;
                n_row    = (row_inc >= i_height) ? 14'd0 : row_inc[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_held   <= '0;
            r_bytes  <= '0;
            r_blocks <= '0;
            r_row    <= '0;
        end else begin
            r_held   <= n_held;
            r_bytes  <= n_bytes;
            r_blocks <= n_blocks;
            r_row    <= n_row;
        end
    end

endmodule

@@ hdl/rbdd_pixel.sv @@
// ----------------------------------------------------------------------------
// rbdd_pixel
// Block buffers and delta reconstruction, one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
module rbdd_pixel
    import rbdd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_blk_v,
    input  t_blk  i_blk,
    input  logic  i_ready,
    output logic  o_pix_v,
    output t_pix  o_pix,
    output t_stat o_stat
);

    t_blk        r_cur, r_pend;
    logic        r_cur_v, r_pend_v;
    logic [3:0]  r_idx;
    t_pix        r_a, n_a;
    logic        r_av;

    logic        adv, emit, last, cur_free;
    logic [10:0] vmax, vmin;
    logic [3:0]  imax, imin, d;
    logic [11:0] diff, p;
    logic [2:0]  sh;
    logic [6:0]  deltas [BLOCK_PIXELS];
    logic [10:0] pv;

    always_comb begin
        adv  = !r_av || i_ready;
        emit = r_cur_v && adv;
        last = (r_idx == 4'd15);
        cur_free = !r_cur_v || (emit && last);

        vmax = r_cur.bits[10:0];
        vmin = r_cur.bits[21:11];
        imax = r_cur.bits[25:22];
        imin = r_cur.bits[29:26];
        diff = {1'b0, vmax} - {1'b0, vmin};
        if (!diff[11] && diff >= 12'd1024)     sh = 3'd4;
        else if (!diff[11] && diff >= 12'd512) sh = 3'd3;
        else if (!diff[11] && diff >= 12'd256) sh = 3'd2;
        else if (!diff[11] && diff >= 12'd128) sh = 3'd1;
        else                                   sh = 3'd0;

        for (int k = 0; k < BLOCK_PIXELS - 1; k++) begin
            deltas[k] = r_cur.bits[30 + 7*k +: 7];
        end
        deltas[BLOCK_PIXELS-1] = '0;

        // Delta slot skips the pixels that hold max and min directly.
        d = r_idx - {3'b0, (imax < r_idx)}
                  - {3'b0, ((imin < r_idx) && (imin != imax))};
        p = ({5'b0, deltas[d]} << sh) + {1'b0, vmin};

        if (r_idx == imax)      pv = vmax;
        else if (r_idx == imin) pv = vmin;
        else if (p > {1'b0, PIX_MAX}) pv = PIX_MAX;
        else                    pv = p[10:0];

        n_a.j        = {pv, 1'b0};
        n_a.col      = r_cur.col + {9'b0, r_idx, 1'b0};
        n_a.row      = r_cur.row;
        n_a.last_blk = last;
        n_a.last_img = last && r_cur.last_img;
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_a <= n_a;
        if (cur_free) r_cur <= r_pend_v ? r_pend : i_blk;
        else if (i_blk_v) r_pend <= i_blk;
        if (!i_rst_n) begin
            r_cur_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
            r_av     <= 1'b0;
        end else begin
            if (adv) r_av <= r_cur_v;
            if (emit) r_idx <= r_idx + 4'd1;
            if (cur_free) begin
                r_cur_v  <= r_pend_v || i_blk_v;
                r_pend_v <= 1'b0;
            end else if (i_blk_v) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    assign o_pix_v        = r_av;
    assign o_pix          = r_a;
    assign o_stat.cur_v   = r_cur_v;
    assign o_stat.pend_v  = r_pend_v;
    assign o_stat.stage_v = r_av;

endmodule

@@ hdl/rbdd_tone.sv @@
// ----------------------------------------------------------------------------
// rbdd_tone
// Piecewise-linear tone curve and the output register.
// ----------------------------------------------------------------------------
module rbdd_tone
    import rbdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [11:0] i_knee [4],
    input  logic        i_pix_v,
    input  t_pix        i_pix,
    output logic        o_ready,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [47:0] o_tdata,
    output logic        o_tlast,
    output logic        o_tuser
);

    logic [11:0] kn [6];
    logic [15:0] r_base [5], n_base [5];
    logic [15:0] val;
    logic [11:0] ofs;
    logic        r_ov;
    logic [14:0] r_value;
    logic [13:0] r_col, r_row;
    logic        r_last, r_user;

    always_comb begin
        kn[0] = 12'd0;
        for (int i = 0; i < 4; i++) kn[i+1] = i_knee[i];
        kn[5] = 12'hfff;

        // Start value of each segment, as left by the segments before it.
        n_base[0] = 16'd0;
        for (int i = 1; i < 5; i++) begin
            n_base[i] = {4'b0, kn[i]};
            for (int s = 0; s < 4; s++) begin
                if (s < i && kn[i] > kn[s] && kn[i] <= kn[s+1]) begin
                    n_base[i] = n_base[s] + ({4'b0, kn[i] - kn[s]} << s);
                end
            end
        end

        val = {4'b0, i_pix.j};
        ofs = '0;
        for (int s = 0; s < 5; s++) begin
            if (i_pix.j > kn[s] && i_pix.j <= kn[s+1]) begin
                ofs = i_pix.j - kn[s];
                val = r_base[s] + ({4'b0, ofs} << s);
            end
        end
    end

    assign o_ready = !r_ov || i_tready;

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        if (i_pix_v && o_ready) begin
            r_value <= val[15:1];
            r_col   <= i_pix.col;
            r_row   <= i_pix.row;
            r_last  <= i_pix.last_blk;
            r_user  <= i_pix.last_img;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_ready) begin
            r_ov <= i_pix_v;
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {5'b0, r_row, r_col, r_value};
    assign o_tlast  = r_last;
    assign o_tuser  = r_user;

endmodule

@@ hdl/raw_block_delta_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// raw_block_delta_decoder_unit
// Decodes delta-compressed raw strips into tone-mapped pixels.
// ----------------------------------------------------------------------------
// Compressed bytes enter on the slave stream, one word per cycle while it is
// ready. Each row takes row_width bytes; every 128 or 135 bits form a block
// of 16 pixels covering every second column. The master stream carries one
// pixel per word, tlast on the sixteenth pixel of a block and tuser on the
// final pixel of the image. A block's first pixel passes the block buffer,
// pixel register and output register, then pixels follow one per cycle while
// the master stream is ready; a block spans at least sixteen bytes, so with
// no stall the sustained rate is one byte and one pixel per cycle. Two block
// buffers (one decoding, one waiting) decouple the streams; the slave side
// stalls only while both are full. Configuration writes use the cfg channel,
// which is always ready, and must be made while idle. Reset clears the row
// and bit counters, empties the buffers and restores the register defaults.
// ----------------------------------------------------------------------------
module raw_block_delta_decoder_unit
    import rbdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // pixel_value, pixel_column, pixel_row
    output logic        o_m_tlast,   // last_of_block
    output logic        o_m_tuser    // last_of_image
);

    logic [11:0] r_knee [4];
    logic [14:0] r_row_width, r_height;
    logic [14:0] width_eff, height_eff;
    logic        accept, blk_v, pix_v, tone_ready;
    t_blk        blk;
    t_pix        pix;
    t_stat       stat;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !stat.pend_v;
    assign accept      = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_row_width == 15'd0) width_eff = 15'd1;
        else if (r_row_width > 15'(MAX_ROW_WIDTH)) width_eff = 15'(MAX_ROW_WIDTH);
        else width_eff = r_row_width;
        if (r_height == 15'd0) height_eff = 15'd1;
        else if (r_height > 15'(MAX_HEIGHT)) height_eff = 15'(MAX_HEIGHT);
        else height_eff = r_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_knee[i] <= 12'hfff;
            r_row_width <= 15'd32;
            r_height    <= 15'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KNEE_ONE:     r_knee[0]   <= i_cfg_data[11:0];
                CFG_KNEE_TWO:     r_knee[1]   <= i_cfg_data[11:0];
                CFG_KNEE_THREE:   r_knee[2]   <= i_cfg_data[11:0];
                CFG_KNEE_FOUR:    r_knee[3]   <= i_cfg_data[11:0];
                CFG_ROW_WIDTH:    r_row_width <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rbdd_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_width  (width_eff),
        .i_height (height_eff),
        .o_blk_v  (blk_v),
        .o_blk    (blk)
    );

    rbdd_pixel u_pixel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk_v (blk_v),
        .i_blk   (blk),
        .i_ready (tone_ready),
        .o_pix_v (pix_v),
        .o_pix   (pix),
        .o_stat  (stat)
    );

    rbdd_tone u_tone (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_knee   (r_knee),
        .i_pix_v  (pix_v),
        .i_pix    (pix),
        .o_ready  (tone_ready),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .o_tuser  (o_m_tuser)
    );

`ifndef SYNTH
    a_pend_needs_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pend_v |-> stat.cur_v)
        else $error("waiting block without a block in decode");
    a_user_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("image end flag off a block end");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast && !stat.cur_v && !stat.stage_v
        |=> !o_m_tvalid)
        else $error("output word without a block behind it");
`endif

endmodule

@@ test/raw_block_delta_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raw_block_delta_decoder_unit_tb
// Self-checking bench for the raw block delta decoder.
// ----------------------------------------------------------------------------
// Compressed bytes are streamed into the block. A local predictor holds its
// own reservoir, counters and tone table, and it queues the pixels that each
// accepted byte should produce. Every output word is compared with the oldest
// queued pixel. The tests cover directed blocks, tone curve knees, row and
// height geometry, back pressure and random well-formed streams under
// varying idle patterns.
// ----------------------------------------------------------------------------
module raw_block_delta_decoder_unit_tb;
    import rbdd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        int unsigned value;
        int unsigned col;
        int unsigned row;
        bit          lb;
        bit          li;
    } t_pixel_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    raw_block_delta_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Predictor state.
    logic [14:0]  reg_knee [4];
    logic [14:0]  reg_width;
    logic [14:0]  reg_height;
    int unsigned  tone_lut [4096];
    logic [143:0] pr_res;
    int unsigned  pr_bits;
    int unsigned  pr_bytes;
    int unsigned  pr_blocks;
    int unsigned  pr_row;

    t_pixel_exp   pixel_queue [$];
    int           fail_count;
    int           snd_idle_pct;
    int           rcv_idle_pct;
    int           hold_cycles;
    int           stall_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned block_col(int unsigned b);
        return 32 * (b >> 1) + (b & 1);
    endfunction

    function automatic void build_tone_lut();
        int unsigned k [6];
        k[0] = 0;
        for (int i = 0; i < 4; i++) k[i+1] = reg_knee[i] & 12'hfff;
        k[5] = 4095;
        for (int j = 0; j < 4096; j++) tone_lut[j] = j;
        for (int i = 0; i < 5; i++)
            for (int j = k[i] + 1; j <= k[i+1]; j++)
                tone_lut[j] = tone_lut[j-1] + (1 << i);
    endfunction

    function automatic int unsigned grab(int unsigned pos, int unsigned n);
        logic [143:0] s;
        s = pr_res >> pos;
        return s[31:0] & ((32'd1 << n) - 32'd1);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int unsigned w, h, x, imx, imn, need, sh, pos, p;
        int          vmax, vmin;
        bit          last_blk;
        t_pixel_exp  e;
        w = reg_width;
        h = reg_height;
        if (w == 0) w = 1;
        if (w > MAX_ROW_WIDTH) w = MAX_ROW_WIDTH;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        x = block_col(pr_blocks);
        if (x + 30 < w && pr_bits + 8 <= RES_BITS) begin
            for (int i = 0; i < 8; i++) pr_res[pr_bits + i] = b[i];
            pr_bits += 8;
            if (pr_bits >= 30) begin
                imx = grab(22, 4);
                imn = grab(26, 4);
                need = (imx == imn) ? 135 : 128;
                if (pr_bits >= need) begin
                    vmax = grab(0, 11);
                    vmin = grab(11, 11);
                    sh = 0;
                    pos = 30;
                    last_blk = block_col(pr_blocks + 1) + 30 >= w;
                    while (sh < 4 && (128 << sh) <= vmax - vmin) sh++;
                    for (int i = 0; i < BLOCK_PIXELS; i++) begin
                        if (i == imx) p = vmax;
                        else if (i == imn) p = vmin;
                        else begin
                            p = (grab(pos, 7) << sh) + vmin;
                            pos += 7;
                            if (p > PIX_MAX) p = PIX_MAX;
                        end
                        e.value = (tone_lut[(p << 1) & 12'hfff] >> 1) & 15'h7fff;
                        e.col   = (x + 2 * i) & 14'h3fff;
                        e.row   = pr_row & 14'h3fff;
                        e.lb    = (i == BLOCK_PIXELS - 1);
                        e.li    = e.lb && last_blk && (pr_row == h - 1);
                        pixel_queue.push_back(e);
                    end
                    pr_res = pr_res >> need;
                    pr_bits = (pr_bits > need) ? pr_bits - need : 0;
                    pr_blocks++;
                end
            end
        end
        pr_bytes++;
        if (pr_bytes >= w) begin
            pr_bytes = 0;
            pr_blocks = 0;
            pr_bits = 0;
            pr_row = (pr_row + 1 >= h) ? 0 : pr_row + 1;
        end
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Receiver: random ready, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Pixel checker.
    always @(posedge i_clk) begin
        t_pixel_exp e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_queue.size() == 0) begin
                report("unexpected pixel", o_m_tdata[28:15], 0);
            end else begin
                e = pixel_queue.pop_front();
                if (o_m_tdata[14:0] != e.value) report("pixel_value", o_m_tdata[14:0], e.value);
                if (o_m_tdata[28:15] != e.col) report("pixel_column", o_m_tdata[28:15], e.col);
                if (o_m_tdata[42:29] != e.row) report("pixel_row", o_m_tdata[42:29], e.row);
                if (o_m_tlast != e.lb) report("last_of_block", o_m_tlast, e.lb);
                if (o_m_tuser != e.li) report("last_of_image", o_m_tuser, e.li);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("raw_block_delta_decoder_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        predict_byte(b);
    endtask

    task automatic send_random(int n);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic finish_row();
        while (pr_bytes != 0) send_byte(8'($urandom_range(255)));
    endtask

    // Sends one well-formed block; deltas are random.
    task automatic send_block(int unsigned vmax, int unsigned vmin,
                              int unsigned imx, int unsigned imn);
        logic [135:0] bits;
        int           nbytes;
        bits = '0;
        for (int i = 30; i < 136; i++) bits[i] = 1'($urandom_range(1));
        bits[10:0]  = 11'(vmax);
        bits[21:11] = 11'(vmin);
        bits[25:22] = 4'(imx);
        bits[29:26] = 4'(imn);
        nbytes = (imx == imn) ? 17 : 16;
        for (int i = 0; i < nbytes; i++) send_byte(bits[8*i +: 8]);
    endtask

    task automatic send_rand_block();
        int unsigned vmin, range, imx;
        vmin = $urandom_range(2047);
        case ($urandom_range(3))
            0: range = $urandom_range(127);
            1: range = $urandom_range(1023);
            2: range = $urandom_range(2047);
            default: range = $urandom_range(4095);
        endcase
        imx = $urandom_range(15);
        send_block((vmin + range) & 11'h7ff, vmin, imx,
                   ($urandom_range(3) == 0) ? imx : $urandom_range(15));
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] val);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KNEE_ONE:     reg_knee[0] = val;
            CFG_KNEE_TWO:     reg_knee[1] = val;
            CFG_KNEE_THREE:   reg_knee[2] = val;
            CFG_KNEE_FOUR:    reg_knee[3] = val;
            CFG_ROW_WIDTH:    reg_width = val;
            CFG_IMAGE_HEIGHT: reg_height = val;
            default: ;
        endcase
        build_tone_lut();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_knees(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
        write_reg(CFG_KNEE_ONE, 15'(a));
        write_reg(CFG_KNEE_TWO, 15'(b));
        write_reg(CFG_KNEE_THREE, 15'(c));
        write_reg(CFG_KNEE_FOUR, 15'(d));
    endtask

    // Full-range block with equal indices, then a header with max below min
    // whose deltas clamp at the pixel maximum.
    task automatic test_directed();
        send_block(11'h7ff, 0, 5, 5);
        finish_row();
        send_block(0, 11'h7ff, 15, 0);
        finish_row();
    endtask

    // Knees in order, out of order, and at the extremes; high data bits set.
    task automatic test_tone_curve();
        set_knees(15'h7000 | 100, 500, 1200, 2400);
        send_rand_block();
        finish_row();
        set_knees(3000, 200, 15'h7fff, 0);
        send_rand_block();
        finish_row();
        set_knees(4095, 4095, 4095, 4095);
    endtask

    // Row widths: zero, above the maximum, and at the maximum.
    task automatic test_row_geometry();
        write_reg(CFG_ROW_WIDTH, 0);
        send_random(3);
        write_reg(CFG_ROW_WIDTH, 15'h7fff);
        send_rand_block();
        write_reg(CFG_ROW_WIDTH, 16384);
        send_rand_block();
        // Shrinking the width mid-row ends the row on the next byte.
        write_reg(CFG_ROW_WIDTH, 32);
        send_random(1);
        finish_row();
    endtask

    // Height wrap, zero height, and a row counter beyond a reduced height.
    task automatic test_height_wrap();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        repeat (3) begin
            send_rand_block();
            finish_row();
        end
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_rand_block();
        finish_row();
        write_reg(CFG_IMAGE_HEIGHT, 1);
        send_rand_block();
        finish_row();
        write_reg(CFG_IMAGE_HEIGHT, 2);
    endtask

    // Receiver holds off long enough for both block buffers to fill.
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (2) begin
            repeat (2) send_rand_block();
            finish_row();
        end
    endtask

    task automatic test_random(int s_pct, int r_pct, int rows);
        snd_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        repeat (rows) begin
            if ($urandom_range(7) == 0) begin
                send_random($urandom_range(40));
            end else begin
                repeat (2) send_rand_block();
            end
            finish_row();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        fail_count   = 0;
        stall_count  = 0;
        hold_cycles  = 0;
        snd_idle_pct = 22;
        rcv_idle_pct = 47;
        for (int i = 0; i < 4; i++) reg_knee[i] = 4095;
        reg_width  = 32;
        reg_height = 1;
        pr_res     = '0;
        pr_bits    = 0;
        pr_bytes   = 0;
        pr_blocks  = 0;
        pr_row     = 0;
        build_tone_lut();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_tone_curve();
        test_row_geometry();
        test_height_wrap();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_backpressure();
        test_random(22, 47, 1);
        set_knees($urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(4095));
        test_random(47, 22, 1);
        set_knees(1000, 1800, 2600, 3400);
        test_random(0, 0, 1);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("raw_block_delta_decoder_unit_tb OK");
        end else begin
            $display("raw_block_delta_decoder_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rbdd_pkg.sv
hdl/rbdd_unpack.sv
hdl/rbdd_pixel.sv
hdl/rbdd_tone.sv
hdl/raw_block_delta_decoder_unit.sv
test/raw_block_delta_decoder_unit_tb.sv
